FILE: hw/rtl/erm_pkg.sv
// shared constants, types and rounding helpers for the euler rotation matrix core
package erm_pkg;

   localparam int ANGLE_BITS_DEF        = 16;
   localparam int COEF_FRAC_BITS_DEF    = 14;
   localparam int SINCOS_ITERATIONS_DEF = 16;

   // output coefficient width and internal fraction bits (q1.30)
   localparam int OUT_BITS  = 16;
   localparam int WORK_FRAC = 30;

   // reciprocal of the cordic gain in q1.30
   localparam logic signed [33:0] CORDIC_K0 = 34'sd652032874;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic signed [33:0] ATAN_TURNS [32] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81,
      34'sd41,        34'sd20,        34'sd10,        34'sd5,
      34'sd3,         34'sd1,         34'sd1,         34'sd0
   };

   typedef struct packed {
      logic signed [31:0] c;
      logic signed [31:0] s;
   } sincos_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] m00;
      logic [OUT_BITS-1:0] m01;
      logic [OUT_BITS-1:0] m02;
      logic [OUT_BITS-1:0] m10;
      logic [OUT_BITS-1:0] m11;
      logic [OUT_BITS-1:0] m12;
      logic [OUT_BITS-1:0] m20;
      logic [OUT_BITS-1:0] m21;
      logic [OUT_BITS-1:0] m22;
   } matrix_type;

   // q1.30 product back to q1.30, ties toward +inf
   function automatic logic signed [31:0] qround(logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + (64'sd1 <<< (WORK_FRAC - 1));
      return t[WORK_FRAC+31:WORK_FRAC];
   endfunction

   // q1.30 sum to saturated q2.frac, ties toward +inf
   function automatic logic [OUT_BITS-1:0] to_coef(logic signed [32:0] v, int frac);
      logic signed [33:0] lim;
      logic signed [33:0] r;
      int sh;
      sh  = WORK_FRAC - frac;
      lim = 34'sd1 <<< frac;
      if (sh == 0) begin
         r = 34'(v);
      end else begin
         r = (34'(v) + (34'sd1 <<< (sh - 1))) >>> sh;
      end
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r[OUT_BITS-1:0];
   endfunction

endpackage

FILE: hw/rtl/erm_sincos_lane.sv
// pipelined rotation-mode cordic lane: binary angle to cosine and sine in q1.30
module erm_sincos_lane #(
   parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF,
   parameter int ITERATIONS = erm_pkg::SINCOS_ITERATIONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic [ANGLE_BITS-1:0]  in_angle,
   output logic                   out_valid,
   input  logic                   out_stall,
   output erm_pkg::sincos_type    out_sc
);

   localparam int RESID_BITS = ANGLE_BITS - 2;
   localparam int SHIFT_UP   = 32 - ANGLE_BITS;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   logic signed [33:0] x_ff    [ITERATIONS+1];
   logic signed [33:0] y_ff    [ITERATIONS+1];
   logic signed [33:0] z_ff    [ITERATIONS+1];
   logic [1:0]         quad_ff [ITERATIONS+1];
   logic [ITERATIONS:0]   valid_ff;
   logic [ITERATIONS+1:0] adv;

   // a stage moves when it is empty or the stage after it moves
   assign adv[ITERATIONS+1] = !out_stall;
   for (genvar k = 0; k <= ITERATIONS; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign in_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 0; k < ITERATIONS; k++) begin
            if (adv[k+1]) begin
               valid_ff[k+1] <= valid_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff[0]    <= erm_pkg::CORDIC_K0;
         y_ff[0]    <= '0;
         z_ff[0]    <= 34'({in_angle[RESID_BITS-1:0], {SHIFT_UP{1'b0}}});
         quad_ff[0] <= in_angle[ANGLE_BITS-1 -: 2];
      end
   end

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
      logic signed [33:0] x_in;
      logic signed [33:0] y_in;
      logic signed [33:0] z_in;
      logic               pos;

      // rotate toward zero residual angle
      assign pos  = !z_ff[k][33];
      assign x_in = pos ? x_ff[k] - (y_ff[k] >>> k) : x_ff[k] + (y_ff[k] >>> k);
      assign y_in = pos ? y_ff[k] + (x_ff[k] >>> k) : y_ff[k] - (x_ff[k] >>> k);
      assign z_in = pos ? z_ff[k] - erm_pkg::ATAN_TURNS[k]
                        : z_ff[k] + erm_pkg::ATAN_TURNS[k];

      always_ff @(posedge clock) begin
         if (adv[k+1]) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            z_ff[k+1]    <= z_in;
            quad_ff[k+1] <= quad_ff[k];
         end
      end
   end

   logic signed [33:0] neg_x;
   logic signed [33:0] neg_y;

   assign neg_x = -x_ff[ITERATIONS];
   assign neg_y = -y_ff[ITERATIONS];

   // quadrant fold
   always_comb begin
      case (quad_ff[ITERATIONS])
         QUAD_FIRST: begin
            out_sc.c = x_ff[ITERATIONS][31:0];
            out_sc.s = y_ff[ITERATIONS][31:0];
         end
         QUAD_SECOND: begin
            out_sc.c = neg_y[31:0];
            out_sc.s = x_ff[ITERATIONS][31:0];
         end
         QUAD_THIRD: begin
            out_sc.c = neg_x[31:0];
            out_sc.s = neg_y[31:0];
         end
         default: begin
            out_sc.c = y_ff[ITERATIONS][31:0];
            out_sc.s = neg_x[31:0];
         end
      endcase
   end

   assign out_valid = valid_ff[ITERATIONS];

endmodule

FILE: hw/rtl/erm_merge.sv
// merge stage: combines the three lanes' cosines and sines into the matrix
module erm_merge #(
   parameter int COEF_FRAC_BITS = erm_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  erm_pkg::sincos_type  in_x,
   input  erm_pkg::sincos_type  in_y,
   input  erm_pkg::sincos_type  in_z,
   output logic                 out_valid,
   input  logic                 out_stall,
   output erm_pkg::matrix_type  out_m
);

   logic [4:0] valid_ff;
   logic [5:0] adv;

   assign adv[5] = !out_stall;
   for (genvar k = 0; k < 5; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign in_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 0; k < 4; k++) begin
            if (adv[k+1]) begin
               valid_ff[k+1] <= valid_ff[k];
            end
         end
      end
   end

   // stage a: first-level products
   logic signed [63:0] pa_czsy_ff, pa_szsy_ff, pa_czcy_ff, pa_szcx_ff, pa_szsx_ff;
   logic signed [63:0] pa_szcy_ff, pa_czcx_ff, pa_czsx_ff, pa_cysx_ff, pa_cycx_ff;
   logic signed [31:0] a_sx_ff, a_cx_ff, a_sy_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pa_czsy_ff <= in_z.c * in_y.s;
         pa_szsy_ff <= in_z.s * in_y.s;
         pa_czcy_ff <= in_z.c * in_y.c;
         pa_szcx_ff <= in_z.s * in_x.c;
         pa_szsx_ff <= in_z.s * in_x.s;
         pa_szcy_ff <= in_z.s * in_y.c;
         pa_czcx_ff <= in_z.c * in_x.c;
         pa_czsx_ff <= in_z.c * in_x.s;
         pa_cysx_ff <= in_y.c * in_x.s;
         pa_cycx_ff <= in_y.c * in_x.c;
         a_sx_ff    <= in_x.s;
         a_cx_ff    <= in_x.c;
         a_sy_ff    <= in_y.s;
      end
   end

   // stage b: round back to q1.30
   logic signed [31:0] b_czsy_ff, b_szsy_ff, b_czcy_ff, b_szcx_ff, b_szsx_ff;
   logic signed [31:0] b_szcy_ff, b_czcx_ff, b_czsx_ff, b_cysx_ff, b_cycx_ff;
   logic signed [31:0] b_sx_ff, b_cx_ff, b_sy_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         b_czsy_ff <= erm_pkg::qround(pa_czsy_ff);
         b_szsy_ff <= erm_pkg::qround(pa_szsy_ff);
         b_czcy_ff <= erm_pkg::qround(pa_czcy_ff);
         b_szcx_ff <= erm_pkg::qround(pa_szcx_ff);
         b_szsx_ff <= erm_pkg::qround(pa_szsx_ff);
         b_szcy_ff <= erm_pkg::qround(pa_szcy_ff);
         b_czcx_ff <= erm_pkg::qround(pa_czcx_ff);
         b_czsx_ff <= erm_pkg::qround(pa_czsx_ff);
         b_cysx_ff <= erm_pkg::qround(pa_cysx_ff);
         b_cycx_ff <= erm_pkg::qround(pa_cycx_ff);
         b_sx_ff   <= a_sx_ff;
         b_cx_ff   <= a_cx_ff;
         b_sy_ff   <= a_sy_ff;
      end
   end

   // stage c: three-factor products
   logic signed [63:0] pc_01_ff, pc_02_ff, pc_11_ff, pc_12_ff;
   logic signed [31:0] c_czcy_ff, c_szcx_ff, c_szsx_ff, c_szcy_ff;
   logic signed [31:0] c_czcx_ff, c_czsx_ff, c_cysx_ff, c_cycx_ff, c_sy_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         pc_01_ff  <= b_czsy_ff * b_sx_ff;
         pc_02_ff  <= b_czsy_ff * b_cx_ff;
         pc_11_ff  <= b_szsy_ff * b_sx_ff;
         pc_12_ff  <= b_szsy_ff * b_cx_ff;
         c_czcy_ff <= b_czcy_ff;
         c_szcx_ff <= b_szcx_ff;
         c_szsx_ff <= b_szsx_ff;
         c_szcy_ff <= b_szcy_ff;
         c_czcx_ff <= b_czcx_ff;
         c_czsx_ff <= b_czsx_ff;
         c_cysx_ff <= b_cysx_ff;
         c_cycx_ff <= b_cycx_ff;
         c_sy_ff   <= b_sy_ff;
      end
   end

   // stage d: matrix sums, row-major
   logic signed [32:0] d_sum_ff [9];

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         d_sum_ff[0] <= 33'(c_czcy_ff);
         d_sum_ff[1] <= 33'(erm_pkg::qround(pc_01_ff)) - 33'(c_szcx_ff);
         d_sum_ff[2] <= 33'(erm_pkg::qround(pc_02_ff)) + 33'(c_szsx_ff);
         d_sum_ff[3] <= 33'(c_szcy_ff);
         d_sum_ff[4] <= 33'(erm_pkg::qround(pc_11_ff)) + 33'(c_czcx_ff);
         d_sum_ff[5] <= 33'(erm_pkg::qround(pc_12_ff)) - 33'(c_czsx_ff);
         d_sum_ff[6] <= -33'(c_sy_ff);
         d_sum_ff[7] <= 33'(c_cysx_ff);
         d_sum_ff[8] <= 33'(c_cycx_ff);
      end
   end

   // stage e: output register, rounded and saturated
   erm_pkg::matrix_type out_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         out_ff.m00 <= erm_pkg::to_coef(d_sum_ff[0], COEF_FRAC_BITS);
         out_ff.m01 <= erm_pkg::to_coef(d_sum_ff[1], COEF_FRAC_BITS);
         out_ff.m02 <= erm_pkg::to_coef(d_sum_ff[2], COEF_FRAC_BITS);
         out_ff.m10 <= erm_pkg::to_coef(d_sum_ff[3], COEF_FRAC_BITS);
         out_ff.m11 <= erm_pkg::to_coef(d_sum_ff[4], COEF_FRAC_BITS);
         out_ff.m12 <= erm_pkg::to_coef(d_sum_ff[5], COEF_FRAC_BITS);
         out_ff.m20 <= erm_pkg::to_coef(d_sum_ff[6], COEF_FRAC_BITS);
         out_ff.m21 <= erm_pkg::to_coef(d_sum_ff[7], COEF_FRAC_BITS);
         out_ff.m22 <= erm_pkg::to_coef(d_sum_ff[8], COEF_FRAC_BITS);
      end
   end

   assign out_valid = valid_ff[4];
   assign out_m     = out_ff;

endmodule

FILE: hw/rtl/euler_rotation_matrix_core.sv
// top level: zyx euler angles to rotation matrix rz*ry*rx
//
// usage
//  - req channel carries three binary angles (full turn = 2^ANGLE_BITS); a
//    transaction completes on a rising edge with req_valid high, req_stall low
//  - rsp channel returns the nine matrix entries m00..m22 as signed q2.14
//    (q2.COEF_FRAC_BITS), rounded to nearest and clamped to +/-1.0
//  - pipeline: an input register and one cordic stage per iteration, then
//    five merge stages (two multiply levels, two rounding levels, output
//    register)
//  - throughput: one transaction per cycle unless rsp_stall holds; three cordic
//    lanes run side by side, one per angle, and share a single merge pipeline
//  - stall: each stage holds only when it is full and the next one holds, so
//    the block keeps accepting requests into empty stages while a response
//    waits on rsp_stall; req_stall rises only once the pipeline is full
//  - reset: synchronous, clears all stage valid bits; no transaction is in
//    flight afterwards and req_stall is low on the first cycle after reset
//  - the transpose (inverse rotation) is not produced; swap rows and columns
module euler_rotation_matrix_core #(
   parameter int ANGLE_BITS        = erm_pkg::ANGLE_BITS_DEF,
   parameter int COEF_FRAC_BITS    = erm_pkg::COEF_FRAC_BITS_DEF,
   parameter int SINCOS_ITERATIONS = erm_pkg::SINCOS_ITERATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ANGLE_BITS-1:0]         req_angle_x,
   input  logic [ANGLE_BITS-1:0]         req_angle_y,
   input  logic [ANGLE_BITS-1:0]         req_angle_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m00,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m01,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m02,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m10,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m11,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m12,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m20,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m21,
   output logic signed [erm_pkg::OUT_BITS-1:0] rsp_m22
);

   // lanes take the same transaction in lock step, so their stalls agree
   logic [2:0]          lane_stall;
   logic [2:0]          lane_valid;
   erm_pkg::sincos_type sc_x;
   erm_pkg::sincos_type sc_y;
   erm_pkg::sincos_type sc_z;
   logic                merge_stall;
   erm_pkg::matrix_type matrix;

   // one cordic lane per axis
   erm_sincos_lane #(
      .ANGLE_BITS (ANGLE_BITS),
      .ITERATIONS (SINCOS_ITERATIONS)
   ) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (lane_stall[0]),
      .in_angle  (req_angle_x),
      .out_valid (lane_valid[0]),
      .out_stall (merge_stall),
      .out_sc    (sc_x)
   );

   erm_sincos_lane #(
      .ANGLE_BITS (ANGLE_BITS),
      .ITERATIONS (SINCOS_ITERATIONS)
   ) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (lane_stall[1]),
      .in_angle  (req_angle_y),
      .out_valid (lane_valid[1]),
      .out_stall (merge_stall),
      .out_sc    (sc_y)
   );

   erm_sincos_lane #(
      .ANGLE_BITS (ANGLE_BITS),
      .ITERATIONS (SINCOS_ITERATIONS)
   ) u_lane_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (lane_stall[2]),
      .in_angle  (req_angle_z),
      .out_valid (lane_valid[2]),
      .out_stall (merge_stall),
      .out_sc    (sc_z)
   );

   // products, sums and output rounding
   erm_merge #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lane_valid[0]),
      .in_stall  (merge_stall),
      .in_x      (sc_x),
      .in_y      (sc_y),
      .in_z      (sc_z),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_m     (matrix)
   );

   assign req_stall = lane_stall[0];

   // unpack the response transaction
   assign rsp_m00 = matrix.m00;
   assign rsp_m01 = matrix.m01;
   assign rsp_m02 = matrix.m02;
   assign rsp_m10 = matrix.m10;
   assign rsp_m11 = matrix.m11;
   assign rsp_m12 = matrix.m12;
   assign rsp_m20 = matrix.m20;
   assign rsp_m21 = matrix.m21;
   assign rsp_m22 = matrix.m22;

`ifndef NO_ASSERTIONS
   localparam int COEF_LIM = 1 << COEF_FRAC_BITS;

   // the three lanes must never drift apart
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (lane_valid[0] == lane_valid[1]) && (lane_valid[0] == lane_valid[2]) &&
      (lane_stall[0] == lane_stall[1]) && (lane_stall[0] == lane_stall[2]))
      else $error("cordic lanes out of step");

   // an empty output register frees the whole stage chain
   a_free_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // diagonal entries stay within the saturation bound
   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (COEF_FRAC_BITS > 14) ||
         ((rsp_m00 <= COEF_LIM) && (rsp_m00 >= -COEF_LIM) &&
          (rsp_m11 <= COEF_LIM) && (rsp_m11 >= -COEF_LIM) &&
          (rsp_m22 <= COEF_LIM) && (rsp_m22 >= -COEF_LIM)))
      else $error("coefficient outside saturation range");
`endif

endmodule

FILE: bench/tb.sv
// self-checking bench for the euler rotation matrix core: directed, random and full-rate angles
module tb;

   // cordic iteration count plus the merge stages at the default build, used for the drain wait at the end
   localparam int PIPE_LATENCY = erm_pkg::SINCOS_ITERATIONS_DEF + 5;
   localparam int CORDIC_STEPS = erm_pkg::SINCOS_ITERATIONS_DEF;
   localparam int COEF_FRAC    = erm_pkg::COEF_FRAC_BITS_DEF;
   localparam int COEF_SHIFT   = 30 - COEF_FRAC;

   // cordic start value (reciprocal of the gain, q1.30), rounding constants and the q2.14 coefficient one
   localparam longint GAIN_INV  = 64'sd652032874;
   localparam longint HALF_Q30  = 64'sd1 <<< 29;
   localparam longint HALF_COEF = 64'sd1 <<< (COEF_SHIFT - 1);
   localparam longint COEF_ONE  = 64'sd1 <<< COEF_FRAC;

   // arctangent of 2^-i, in units of 2^-32 turn
   localparam longint ATAN_STEP [16] = '{
      64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
      64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
      64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
      64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
   };

   // corner angles: zero, full scale, quadrant edges, gimbal lock, octants, bit patterns
   localparam int NUM_CORNERS = 20;
   localparam logic [47:0] CORNER_ANGLES [NUM_CORNERS] = '{
      {16'h0000, 16'h0000, 16'h0000}, {16'hFFFF, 16'hFFFF, 16'hFFFF},
      {16'h4000, 16'h0000, 16'h0000}, {16'h0000, 16'h4000, 16'h0000},
      {16'h0000, 16'h0000, 16'h4000}, {16'h8000, 16'h8000, 16'h8000},
      {16'hC000, 16'hC000, 16'hC000}, {16'h3FFF, 16'h7FFF, 16'hBFFF},
      {16'h2000, 16'h2000, 16'h2000}, {16'h0000, 16'h4000, 16'h4000},
      {16'h1234, 16'hC000, 16'h0F00}, {16'h8000, 16'h0000, 16'hC000},
      {16'hFFFF, 16'h0000, 16'h0001}, {16'h0001, 16'hFFFF, 16'h8000},
      {16'hAAAA, 16'h5555, 16'hAAAA}, {16'h5555, 16'hAAAA, 16'h5555},
      {16'h4001, 16'hBFFF, 16'hC001}, {16'hE000, 16'h6000, 16'hA000},
      {16'h7FFF, 16'h8001, 16'h3FFF}, {16'h6000, 16'hE000, 16'h2000}
   };

   typedef enum logic [1:0] {QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH} quadrant_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC}
      stall_mode_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [15:0] req_angle_x = '0;
   logic [15:0] req_angle_y = '0;
   logic [15:0] req_angle_z = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic signed [erm_pkg::OUT_BITS-1:0] rsp_m00, rsp_m01, rsp_m02;
   logic signed [erm_pkg::OUT_BITS-1:0] rsp_m10, rsp_m11, rsp_m12;
   logic signed [erm_pkg::OUT_BITS-1:0] rsp_m20, rsp_m21, rsp_m22;

   // matrices still owed by the core, oldest first
   erm_pkg::matrix_type pending_matrices [$];
   int             mismatch_count = 0;
   stall_mode_type stall_mode     = STALL_NONE;
   int             stall_mode_left = 0;
   int unsigned    cycle_count    = 0;
   string          entry_names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                                       "m20", "m21", "m22"};

   euler_rotation_matrix_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_angle_x(req_angle_x),
      .req_angle_y(req_angle_y),
      .req_angle_z(req_angle_z),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_m00    (rsp_m00),
      .rsp_m01    (rsp_m01),
      .rsp_m02    (rsp_m02),
      .rsp_m10    (rsp_m10),
      .rsp_m11    (rsp_m11),
      .rsp_m12    (rsp_m12),
      .rsp_m20    (rsp_m20),
      .rsp_m21    (rsp_m21),
      .rsp_m22    (rsp_m22)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor: cordic sine/cosine per angle, then the zyx product in q1.30
   // ---------------------------------------------------------------------

   // rotation-mode cordic over the low 14 bits, quadrant folded in afterwards
   function automatic void angle_sincos(input logic [15:0] ang, output longint cos_v,
                                        output longint sin_v);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = GAIN_INV;
      y = 0;
      z = longint'({ang[13:0], 16'h0000});
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_STEP[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_STEP[i];
         end
      end
      case (quadrant_type'(ang[15:14]))
         QUAD_FIRST: begin
            cos_v = x;
            sin_v = y;
         end
         QUAD_SECOND: begin
            cos_v = -y;
            sin_v = x;
         end
         QUAD_THIRD: begin
            cos_v = -x;
            sin_v = -y;
         end
         default: begin
            cos_v = y;
            sin_v = -x;
         end
      endcase
   endfunction

   // q1.30 times q1.30, rounded back to q1.30 with ties toward +inf
   function automatic longint q30_mul(longint a, longint b);
      return (a * b + HALF_Q30) >>> 30;
   endfunction

   // q1.30 to saturated q2.14, ties toward +inf
   function automatic logic [erm_pkg::OUT_BITS-1:0] q30_to_coef(longint v);
      longint r;
      r = (v + HALF_COEF) >>> COEF_SHIFT;
      if (r > COEF_ONE) begin
         r = COEF_ONE;
      end
      if (r < -COEF_ONE) begin
         r = -COEF_ONE;
      end
      return r[erm_pkg::OUT_BITS-1:0];
   endfunction

   function automatic erm_pkg::matrix_type rotation_matrix(logic [15:0] ax, logic [15:0] ay,
                                                           logic [15:0] az);
      longint              cx, sx, cy, sy, cz, sz;
      longint              czsy;
      longint              szsy;
      erm_pkg::matrix_type m;
      angle_sincos(ax, cx, sx);
      angle_sincos(ay, cy, sy);
      angle_sincos(az, cz, sz);
      czsy  = q30_mul(cz, sy);
      szsy  = q30_mul(sz, sy);
      m.m00 = q30_to_coef(q30_mul(cz, cy));
      m.m01 = q30_to_coef(q30_mul(czsy, sx) - q30_mul(sz, cx));
      m.m02 = q30_to_coef(q30_mul(czsy, cx) + q30_mul(sz, sx));
      m.m10 = q30_to_coef(q30_mul(sz, cy));
      m.m11 = q30_to_coef(q30_mul(szsy, sx) + q30_mul(cz, cx));
      m.m12 = q30_to_coef(q30_mul(szsy, cx) - q30_mul(cz, sx));
      m.m20 = q30_to_coef(-sy);
      m.m21 = q30_to_coef(q30_mul(cy, sx));
      m.m22 = q30_to_coef(q30_mul(cy, cx));
      return m;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // present one angle triple and hold it until the core takes it; valid stays
   // high afterwards so a burst runs without a bubble
   task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      if (!req_valid) begin
         req_valid <= 1'b1;
      end
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      // transaction taken at this edge
      pending_matrices.push_back(rotation_matrix(ax, ay, az));
   endtask

   // half of them arbitrary angles, the rest hugging quadrant edges or on steps of 1/32 turn
   function automatic logic [15:0] random_angle();
      case ($urandom_range(0, 3))
         0, 1:    return 16'($urandom);
         2:       return 16'({2'($urandom_range(0, 3)), 14'h0000} + $urandom_range(0, 8) - 4);
         default: return 16'($urandom_range(0, 31) * 16'h0800);
      endcase
   endfunction

   task automatic test_corner_angles();
      for (int i = 0; i < NUM_CORNERS; i++) begin
         send_angles(CORNER_ANGLES[i][47:32], CORNER_ANGLES[i][31:16],
                     CORNER_ANGLES[i][15:0]);
      end
   endtask

   // bursts of random length, random gaps between them, some bursts run straight on
   task automatic test_random_bursts(int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 16);
         for (int j = 0; j < burst && sent < count; j++) begin
            send_angles(random_angle(), random_angle(), random_angle());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   // one long unbroken stream so the pipeline fills and req_stall comes up
   task automatic test_full_rate(int count);
      for (int i = 0; i < count; i++) begin
         send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   // receiver stall: switches between no stall, light, heavy and a square wave
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_mode_type'($urandom_range(0, 3));
         stall_mode_left <= $urandom_range(20, 200);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) != 0);
         default:     rsp_stall <= cycle_count[3];
      endcase
   end

   // compare every taken response with the oldest outstanding matrix
   always @(posedge clock) begin
      erm_pkg::matrix_type          want;
      erm_pkg::matrix_type          got;
      logic [erm_pkg::OUT_BITS-1:0] want_e;
      logic [erm_pkg::OUT_BITS-1:0] got_e;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (pending_matrices.size() == 0) begin
            $display("%0t: response with nothing outstanding, m00=%0d", $time, rsp_m00);
            mismatch_count++;
         end else begin
            want = pending_matrices.pop_front();
            for (int k = 0; k < 9; k++) begin
               // m00 sits in the top bits of the packed matrix
               want_e = want[(8 - k) * erm_pkg::OUT_BITS +: erm_pkg::OUT_BITS];
               got_e  = got[(8 - k) * erm_pkg::OUT_BITS +: erm_pkg::OUT_BITS];
               if (want_e !== got_e) begin
                  $display("%0t: %s expected %0d actual %0d", $time, entry_names[k],
                           $signed(want_e), $signed(got_e));
                  mismatch_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_angles();
      test_random_bursts(650);
      test_full_rate(100);
      req_valid <= 1'b0;
      // drain, then leave room for any stray response
      while (pending_matrices.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #3000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/erm_pkg.sv
hw/rtl/erm_sincos_lane.sv
hw/rtl/erm_merge.sv
hw/rtl/euler_rotation_matrix_core.sv
bench/tb.sv
